[hdl/assert_macros.svh]
// Assertion macros shared by the RTL; all expand to nothing under NO_ASSERTIONS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/nq_pkg.sv]
// Shared types and constants of the note onset quantizer.
package nq_pkg;

  localparam logic [1:0] OP_NOTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_PULSE = 2'd2;

  localparam logic [1:0] REG_ENABLED     = 2'd0;
  localparam logic [1:0] REG_QUANTIZE_ON = 2'd1;
  localparam logic [1:0] REG_NOTE_REPEAT = 2'd2;

  localparam logic [8:0] UNITY_STRENGTH = 9'd256;
  localparam logic [6:0] VEL_MAX        = 7'd127;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // latch the input item
    logic start_walk;  // clear walk index, note a pulse
    logic note;        // process a note event
    logic walk_off;    // emit and clear a pending off at the walk index
    logic walk_on;     // emit the onset at the walk index
    logic next_idx;    // step the walk index
    logic flush;       // release the held result as the last one
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] op;
    logic       pulse_seen;
    logic       need_off;
    logic       need_on;
    logic       idx_last;
    logic       can_emit;
    logic       hold_valid;
    logic       out_free;
  } stat_t;

endpackage

[hdl/nq_ctrl.sv]
// Sequencing controller of the note onset quantizer.
module nq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  nq_pkg::stat_t stat,
  output nq_pkg::cmd_t  cmd
);
  import nq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_NOTE     = 3'd2;
  localparam logic [2:0] S_WALK_OFF = 3'd3;
  localparam logic [2:0] S_WALK_ON  = 3'd4;
  localparam logic [2:0] S_FLUSH    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_NOTE: begin
            state_next = S_NOTE;
          end
          OP_TICK: begin
            if (!stat.pulse_seen) begin
              cmd.start_walk = 1'b1;
              state_next     = S_WALK_OFF;
            end else begin
              state_next = S_FLUSH;
            end
          end
          OP_PULSE: begin
            cmd.start_walk = 1'b1;
            state_next     = S_WALK_OFF;
          end
          default: begin
            state_next = S_FLUSH;
          end
        endcase
      end
      S_NOTE: begin
        if (stat.can_emit) begin
          cmd.note   = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_WALK_OFF: begin
        if (!stat.need_off || stat.can_emit) begin
          cmd.walk_off = 1'b1;
          state_next   = S_WALK_ON;
        end
      end
      S_WALK_ON: begin
        if (!stat.need_on || stat.can_emit) begin
          cmd.walk_on = 1'b1;
          if (stat.idx_last) begin
            state_next = S_FLUSH;
          end else begin
            cmd.next_idx = 1'b1;
            state_next   = S_WALK_OFF;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.hold_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/nq_dp.sv]
// Datapath of the note onset quantizer: registers, pitch table, scaling and result staging.
module nq_dp #(
  parameter int NUM_PITCHES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic              cfg_data,
  input  logic [1:0]        operation,
  input  logic [6:0]        pitch,
  input  logic [6:0]        velocity,
  input  logic signed [8:0] voice,
  input  logic [8:0]        strength,
  input  nq_pkg::cmd_t      cmd,
  output nq_pkg::stat_t     stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [6:0]        out_pitch,
  output logic [6:0]        out_velocity,
  output logic signed [8:0] out_voice,
  output logic              last
);
  import nq_pkg::*;

  localparam int IDX_W = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;

  logic enabled;
  logic quantize_on;
  logic note_repeat;

  logic [1:0] cur_op;
  logic [6:0] cur_pitch;
  logic [6:0] cur_vel;
  logic [8:0] cur_voice;
  logic [8:0] cur_strength;

  logic [6:0]             tbl_vel   [NUM_PITCHES];
  logic [8:0]             tbl_voice [NUM_PITCHES];
  logic [NUM_PITCHES-1:0] held;
  logic [NUM_PITCHES-1:0] played;
  logic [NUM_PITCHES-1:0] offp;
  logic [NUM_PITCHES-1:0] offpre;
  logic                   pulse_seen;
  logic [IDX_W-1:0]       idx;

  logic       hold_valid;
  logic [6:0] hold_pitch;
  logic [6:0] hold_vel;
  logic [8:0] hold_voice;

  logic [IDX_W-1:0] rd_addr;
  logic [6:0]       rd_vel;
  logic [8:0]       rd_voice;
  logic             passthrough;
  logic             in_range;
  logic             retrig;
  logic [8:0]       scale;
  logic [15:0]      prod;
  logic [6:0]       on_vel;
  logic             out_free;
  logic             can_emit;
  logic             emit;
  logic [6:0]       e_pitch;
  logic [6:0]       e_vel;
  logic [8:0]       e_voice;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b1;
      quantize_on <= 1'b1;
      note_repeat <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLED:     enabled     <= cfg_data;
        REG_QUANTIZE_ON: quantize_on <= cfg_data;
        REG_NOTE_REPEAT: note_repeat <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_op       <= operation;
      cur_pitch    <= pitch;
      cur_vel      <= velocity;
      cur_voice    <= voice;
      cur_strength <= strength;
    end
  end

  // One shared table read port: pitch for note events, walk index otherwise.
  assign rd_addr     = (cur_op == OP_NOTE) ? cur_pitch[IDX_W-1:0] : idx;
  assign rd_vel      = tbl_vel[rd_addr];
  assign rd_voice    = tbl_voice[rd_addr];
  assign passthrough = !enabled || !quantize_on;
  assign in_range    = ({1'b0, cur_pitch} < 8'(NUM_PITCHES));
  assign retrig      = (offp[rd_addr] || offpre[rd_addr] || held[rd_addr]) &&
                       (rd_voice != cur_voice);

  assign scale  = (cur_op == OP_PULSE) ? cur_strength : UNITY_STRENGTH;
  assign prod   = 16'(rd_vel) * 16'(scale);
  assign on_vel = (prod[15:8] > 8'(VEL_MAX)) ? VEL_MAX : prod[14:8];

  assign out_free = !out_valid || !out_stall;
  assign can_emit = !hold_valid || out_free;

  always_comb begin
    emit    = 1'b0;
    e_pitch = cur_pitch;
    e_vel   = 7'd0;
    e_voice = rd_voice;
    if (cmd.note) begin
      if (passthrough) begin
        emit    = 1'b1;
        e_vel   = cur_vel;
        e_voice = cur_voice;
      end else if (in_range && (cur_vel != 7'd0) && retrig) begin
        emit = 1'b1;
      end
    end
    if (cmd.walk_off && offp[rd_addr]) begin
      emit    = 1'b1;
      e_pitch = 7'(idx);
    end
    if (cmd.walk_on && (rd_vel != 7'd0)) begin
      emit    = 1'b1;
      e_pitch = 7'(idx);
      e_vel   = on_vel;
    end
  end

  // Pitch table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PITCHES; i++) begin
        tbl_vel[i]   <= 7'd0;
        tbl_voice[i] <= 9'd0;
      end
      held       <= '0;
      played     <= '0;
      offp       <= '0;
      offpre     <= '0;
      pulse_seen <= 1'b0;
      idx        <= '0;
    end else begin
      if (cmd.start_walk) begin
        idx <= '0;
        if (cur_op == OP_PULSE) begin
          pulse_seen <= 1'b1;
        end
      end
      if (cmd.next_idx) begin
        idx <= idx + 1'b1;
      end
      if (cmd.note && !passthrough && in_range) begin
        if (cur_vel != 7'd0) begin
          if (retrig) begin
            offp[rd_addr]   <= 1'b0;
            offpre[rd_addr] <= 1'b0;
          end
          tbl_vel[rd_addr]   <= cur_vel;
          tbl_voice[rd_addr] <= cur_voice;
          held[rd_addr]      <= 1'b1;
          played[rd_addr]    <= 1'b0;
        end else begin
          if (played[rd_addr]) begin
            offp[rd_addr] <= 1'b1;
          end else begin
            offpre[rd_addr] <= 1'b1;
          end
          if (note_repeat) begin
            tbl_vel[rd_addr] <= 7'd0;
          end
          held[rd_addr] <= 1'b0;
        end
      end
      if (cmd.walk_off) begin
        offp[rd_addr] <= 1'b0;
      end
      if (cmd.walk_on && (rd_vel != 7'd0)) begin
        played[rd_addr] <= 1'b1;
        if (!note_repeat) begin
          tbl_vel[rd_addr] <= 7'd0;
        end
        if (note_repeat || offpre[rd_addr]) begin
          offp[rd_addr] <= 1'b1;
        end
        offpre[rd_addr] <= 1'b0;
      end
    end
  end

  // One-deep hold so the final result of a run can be marked last.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (emit) begin
      hold_valid <= 1'b1;
    end else if (cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold_pitch <= e_pitch;
      hold_vel   <= e_vel;
      hold_voice <= e_voice;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((emit && hold_valid) || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((emit && hold_valid) || cmd.flush) begin
      out_pitch    <= hold_pitch;
      out_velocity <= hold_vel;
      out_voice    <= hold_voice;
      last         <= cmd.flush;
    end
  end

  assign stat.op         = cur_op;
  assign stat.pulse_seen = pulse_seen;
  assign stat.need_off   = offp[rd_addr];
  assign stat.need_on    = (rd_vel != 7'd0);
  assign stat.idx_last   = (idx == IDX_W'(NUM_PITCHES - 1));
  assign stat.can_emit   = can_emit;
  assign stat.hold_valid = hold_valid;
  assign stat.out_free   = out_free;

endmodule

[hdl/note_onset_quantizer.sv]
// Note onset quantizer: holds notes in a per-pitch table and releases them on grid ticks.
// Note event: its result, if any, goes through the hold and out marked last; input stalls till then.
// Tick or pulse: the walk gives each table entry an off step and an onset step, since an
// entry may give an off and an onset and one result moves per cycle when the output is free;
// a tick after the first pulse is ignored. One item at a time; output stalls hold any result.
// Synchronous reset clears table, pulse flag and handshakes; enabled, quantize_on 1, repeat 0.
`include "assert_macros.svh"

module note_onset_quantizer #(
  parameter int NUM_PITCHES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        operation,
  input  logic [6:0]        pitch,
  input  logic [6:0]        velocity,
  input  logic signed [8:0] voice,
  input  logic [8:0]        strength,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        out_pitch,
  output logic [6:0]        out_velocity,
  output logic signed [8:0] out_voice,
  output logic              last
);
  import nq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  nq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  nq_dp #(
    .NUM_PITCHES (NUM_PITCHES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (operation),
    .pitch        (pitch),
    .velocity     (velocity),
    .voice        (voice),
    .strength     (strength),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_pitch    (out_pitch),
    .out_velocity (out_velocity),
    .out_voice    (out_voice),
    .last         (last)
  );

  // A new item never finds a result left in the hold.
  `ASSERT_IMPLIES(a_accept_hold_empty, in_valid && !in_stall, !stat.hold_valid)
  // At most one table step per cycle.
  `ASSERT_ALWAYS(a_one_step, $onehot0({cmd.note, cmd.walk_off, cmd.walk_on, cmd.flush}))
  // Final result only moves into a free output register.
  `ASSERT_IMPLIES(a_flush_free, cmd.flush, stat.out_free)
  // After the last result the block takes input again.
  `ASSERT_NEXT(a_flush_idle, cmd.flush, !in_stall && out_valid && last)

endmodule

[test/tb.sv]
// Testbench for note_onset_quantizer: random and directed note, tick and pulse traffic.
`timescale 1ns / 1ps

module tb;
  import nq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TABLE_SIZE = 32;
  localparam int WALK_SLACK = 100;   // room for a walk with nothing to emit, which still stalls the input
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 5000;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [1:0] op;
    logic [6:0] pitch;
    logic [6:0] vel;
    logic [8:0] voice;
    logic [8:0] strength;
  } note_event_t;

  typedef struct {
    logic [6:0] pitch;
    logic [6:0] vel;
    logic [8:0] voice;
    logic       last;
  } note_out_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_ENABLED;
  logic              cfg_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        operation = OP_NOTE;
  logic [6:0]        pitch = '0;
  logic [6:0]        velocity = '0;
  logic signed [8:0] voice = '0;
  logic [8:0]        strength = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [6:0]        out_pitch;
  logic [6:0]        out_velocity;
  logic signed [8:0] out_voice;
  logic              last;

  note_onset_quantizer i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .pitch(pitch), .velocity(velocity), .voice(voice),
    .strength(strength),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pitch(out_pitch), .out_velocity(out_velocity), .out_voice(out_voice), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  idle_mode_t  mode = IDLE_NONE;
  note_event_t pending_events[$];
  note_out_t   expected_notes[$];
  note_out_t   walk_run[$];
  int          errors = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          stuck_cycles = 0;

  // Shadow of the quantizer state
  logic       q_enabled = 1'b1;
  logic       q_quantize = 1'b1;
  logic       q_repeat = 1'b0;
  logic [6:0] slot_vel[TABLE_SIZE];
  logic [8:0] slot_voice[TABLE_SIZE];
  logic       slot_held[TABLE_SIZE];
  logic       slot_played[TABLE_SIZE];
  logic       slot_off_due[TABLE_SIZE];
  logic       slot_off_early[TABLE_SIZE];
  logic       pulse_heard = 1'b0;

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_vel[i] = '0;
      slot_voice[i] = '0;
      slot_held[i] = 1'b0;
      slot_played[i] = 1'b0;
      slot_off_due[i] = 1'b0;
      slot_off_early[i] = 1'b0;
    end
  end

  function automatic void emit_note(logic [6:0] p, logic [6:0] v, logic [8:0] vc);
    note_out_t n;
    n.pitch = p;
    n.vel = v;
    n.voice = vc;
    n.last = 1'b0;
    walk_run.push_back(n);
  endfunction

  function automatic void walk_grid(logic [8:0] st);
    int scaled;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (slot_off_due[i]) begin
        emit_note(7'(i), 7'd0, slot_voice[i]);
        slot_off_due[i] = 1'b0;
      end
      if (slot_vel[i] != 0) begin
        scaled = (int'(slot_vel[i]) * int'(st)) >> 8;
        if (scaled > int'(VEL_MAX))
          scaled = int'(VEL_MAX);
        emit_note(7'(i), 7'(scaled), slot_voice[i]);
        slot_played[i] = 1'b1;
        if (!q_repeat)
          slot_vel[i] = '0;
        else
          slot_off_due[i] = 1'b1;
        if (slot_off_early[i]) begin
          slot_off_early[i] = 1'b0;
          slot_off_due[i] = 1'b1;
        end
      end
    end
  endfunction

  // Advance the shadow state by one accepted input and queue what it releases.
  function automatic void quantize_event(note_event_t ev);
    int p;
    note_out_t n;
    walk_run.delete();
    p = int'(ev.pitch);
    case (ev.op)
      OP_NOTE: begin
        if (!q_enabled || !q_quantize) begin
          emit_note(ev.pitch, ev.vel, ev.voice);
        end else if (p < TABLE_SIZE) begin
          if (ev.vel != 0) begin
            // retrigger from another voice cuts the old note right away
            if ((slot_off_due[p] || slot_off_early[p] || slot_held[p]) &&
                slot_voice[p] != ev.voice) begin
              emit_note(ev.pitch, 7'd0, slot_voice[p]);
              slot_off_due[p] = 1'b0;
              slot_off_early[p] = 1'b0;
            end
            slot_vel[p] = ev.vel;
            slot_voice[p] = ev.voice;
            slot_held[p] = 1'b1;
            slot_played[p] = 1'b0;
          end else begin
            if (slot_played[p])
              slot_off_due[p] = 1'b1;
            else
              slot_off_early[p] = 1'b1;
            if (q_repeat)
              slot_vel[p] = '0;
            slot_held[p] = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (!pulse_heard)
          walk_grid(UNITY_STRENGTH);
      end
      OP_PULSE: begin
        pulse_heard = 1'b1;
        walk_grid(ev.strength);
      end
      default: ;
    endcase
    for (int i = 0; i < walk_run.size(); i++) begin
      n = walk_run[i];
      n.last = (i == walk_run.size() - 1);
      expected_notes.push_back(n);
    end
  endfunction

  function automatic logic sender_gap();
    case (mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 70;
      IDLE_BOTH:   return $urandom_range(0, 99) < 10;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_gap();
    case (mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 70;
      IDLE_BOTH:     return $urandom_range(0, 99) < 10;
      default:       return 1'b0;
    endcase
  endfunction

  // Input driver
  always @(posedge clk) begin : drive_in
    note_event_t ev;
    note_event_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.op = operation;
        cur.pitch = pitch;
        cur.vel = velocity;
        cur.voice = voice;
        cur.strength = strength;
        quantize_event(cur);
      end
      if (!in_valid || !in_stall) begin
        if (pending_events.size() > 0 && !sender_gap()) begin
          ev = pending_events.pop_front();
          in_valid <= 1'b1;
          operation <= ev.op;
          pitch <= ev.pitch;
          velocity <= ev.vel;
          voice <= ev.voice;
          strength <= ev.strength;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_gap();
    end
  end

  task automatic compare_field(string label, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
      errors++;
    end
  endtask

  // Output monitor
  always @(posedge clk) begin : watch_out
    note_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_notes.size() == 0) begin
        $display("%0t: unexpected result pitch %0d velocity %0d voice %0d last %0b",
                 $time, out_pitch, out_velocity, out_voice, last);
        errors++;
      end else begin
        want = expected_notes.pop_front();
        compare_field("out_pitch", int'(want.pitch), int'(out_pitch));
        compare_field("out_velocity", int'(want.vel), int'(out_velocity));
        compare_field("out_voice", int'($signed(want.voice)), int'(out_voice));
        compare_field("last", int'(want.last), int'(last));
      end
    end
  end

  // Watchdog on transfers of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_event(logic [1:0] op, logic [6:0] p, logic [6:0] v, logic [8:0] vc,
                            logic [8:0] st);
    note_event_t ev;
    ev.op = op;
    ev.pitch = p;
    ev.vel = v;
    ev.voice = vc;
    ev.strength = st;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLED:     q_enabled = val;
      REG_QUANTIZE_ON: q_quantize = val;
      REG_NOTE_REPEAT: q_repeat = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic en, logic quant, logic rep);
    write_reg(REG_ENABLED, en);
    write_reg(REG_QUANTIZE_ON, quant);
    write_reg(REG_NOTE_REPEAT, rep);
    @(negedge clk);
  endtask

  // Sender pauses until everything is out, then leaves room for a silent walk.
  task automatic drain();
    while (pending_events.size() > 0 || in_valid || expected_notes.size() > 0)
      @(negedge clk);
    repeat (WALK_SLACK) @(negedge clk);
  endtask

  // Mostly note traffic on a few pitches and voices so retriggers and offs collide.
  task automatic add_random(int count, logic use_pulse);
    logic [1:0] op;
    logic [6:0] p;
    logic [6:0] v;
    logic [8:0] vc;
    logic [8:0] st;
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      p = 7'($urandom);
      v = 7'($urandom);
      vc = 9'($urandom);
      st = 9'($urandom);
      if (roll < 60) begin
        op = OP_NOTE;
        roll = $urandom_range(0, 99);
        if (roll < 60)
          p = 7'($urandom_range(0, 7));
        else if (roll < 90)
          p = 7'($urandom_range(8, TABLE_SIZE - 1));
        else
          p = 7'($urandom_range(TABLE_SIZE, 127));
        if ($urandom_range(0, 99) < 35)
          v = '0;
        else
          v = 7'($urandom_range(1, 127));
        roll = $urandom_range(0, 99);
        if (roll < 60)
          vc = 9'($urandom_range(0, 3));
        else if (roll < 75)
          vc = 9'h1FF;
      end else if (roll < 90) begin
        op = use_pulse ? OP_PULSE : OP_TICK;
        roll = $urandom_range(0, 99);
        if (roll < 40)
          st = UNITY_STRENGTH;
        else if (roll < 70)
          st = 9'($urandom_range(64, 320));
      end else begin
        op = (use_pulse && $urandom_range(0, 1) == 1) ? OP_TICK : OP_UNUSED;
      end
      push_event(op, p, v, vc, st);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ticks walk the table only until the first pulse, so they go first.
    push_event(OP_NOTE, 7'd0, 7'd127, 9'd0, 9'd0);
    push_event(OP_NOTE, 7'd31, 7'd1, 9'd255, 9'd0);
    push_event(OP_NOTE, 7'd32, 7'd50, 9'd3, 9'd0);       // beyond the table
    push_event(OP_NOTE, 7'd127, 7'd127, 9'h1FF, 9'h1FF);
    push_event(OP_TICK, 7'd0, 7'd0, 9'd0, 9'd0);          // strength field ignored
    push_event(OP_NOTE, 7'd0, 7'd0, 9'd0, 9'd0);          // off after onset played
    push_event(OP_NOTE, 7'd5, 7'd100, 9'd1, 9'd0);
    push_event(OP_NOTE, 7'd5, 7'd90, 9'd2, 9'd0);         // retrigger, other voice
    push_event(OP_NOTE, 7'd5, 7'd80, 9'd2, 9'd0);         // same voice, no cut
    push_event(OP_NOTE, 7'd5, 7'd0, 9'd2, 9'd0);          // off before it ever played
    push_event(OP_UNUSED, 7'h7F, 7'h7F, 9'h1FF, 9'h1FF);
    push_event(OP_TICK, 7'd0, 7'd0, 9'd0, 9'h1FF);
    push_event(OP_TICK, 7'd0, 7'd0, 9'd0, 9'd0);
    push_event(OP_TICK, 7'd0, 7'd0, 9'd0, 9'd0);          // nothing left to emit
    hold_requests <= hold_requests + 1;
    add_random(60, 1'b0);
    drain();

    push_event(OP_NOTE, 7'd3, 7'd127, 9'h1FF, 9'd0);
    push_event(OP_NOTE, 7'd4, 7'd64, 9'h100, 9'd0);
    push_event(OP_PULSE, 7'd0, 7'd0, 9'd0, 9'h1FF);       // saturates
    push_event(OP_NOTE, 7'd3, 7'd127, 9'h1FF, 9'd0);
    push_event(OP_PULSE, 7'd0, 7'd0, 9'd0, 9'd0);         // onset scaled down to zero
    push_event(OP_NOTE, 7'd8, 7'd10, 9'd6, 9'd0);
    push_event(OP_TICK, 7'd0, 7'd0, 9'd0, 9'd0);          // ignored once pulses run
    push_event(OP_PULSE, 7'd0, 7'd0, 9'd0, 9'd128);
    drain();

    set_config(1'b1, 1'b1, 1'b1);
    mode = IDLE_SENDER;
    add_random(70, 1'b1);
    drain();

    set_config(1'b0, 1'b1, 1'b0);
    mode = IDLE_RECEIVER;
    add_random(50, 1'b1);
    drain();

    set_config(1'b1, 1'b0, 1'b1);
    mode = IDLE_BOTH;
    add_random(50, 1'b1);
    drain();

    set_config(1'b1, 1'b1, 1'b0);
    mode = IDLE_RECEIVER;
    add_random(80, 1'b1);
    drain();

    set_config(1'b1, 1'b1, 1'b1);
    mode = IDLE_BOTH;
    add_random(80, 1'b1);
    drain();

    if (errors == 0 && expected_notes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
